/* hw/rtl/wfs_pkg.sv */
// shared types, codes and helpers of the wavefront filter scoreboard
`default_nettype none

package wfs_pkg;

  localparam int WFS_MAX_ROWS    = 256;
  localparam int WFS_MAX_COLUMNS = 256;

  localparam int ACT_W   = 3;
  localparam int ROW_W   = 8;
  localparam int COUNT_W = 9;
  localparam int STAGE_W = 2;
  localparam int FAULT_W = 3;
  localparam int CFG_W   = 9;
  localparam int CIDX_W  = 2;

  typedef enum logic [ACT_W-1:0] {
    ACT_START   = 3'd0,
    ACT_PUBLISH = 3'd1,
    ACT_QUERY   = 3'd2,
    ACT_CLAIM   = 3'd3,
    ACT_FINISH  = 3'd4,
    ACT_FAULT   = 3'd5
  } action_t;

  localparam logic [CIDX_W-1:0] CFG_ROWS    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_COLUMNS = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_DEBLOCK = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_SAO     = 2'd3;

  localparam logic [STAGE_W-1:0] STG_DBK_V = 2'd0;
  localparam logic [STAGE_W-1:0] STG_DBK_H = 2'd1;
  localparam logic [STAGE_W-1:0] STG_SAO_A = 2'd2;
  localparam logic [STAGE_W-1:0] STG_SAO_B = 2'd3;

  localparam logic [1:0] OFS_ABOVE = 2'd0;
  localparam logic [1:0] OFS_SELF  = 2'd1;
  localparam logic [1:0] OFS_BELOW = 2'd2;

  // clamped picture geometry and stage enables
  typedef struct packed {
    logic [CFG_W-1:0] rows;
    logic [CFG_W-1:0] cols;
    logic             deblock;
    logic             sao;
  } wfs_cfg_t;

  // which neighbor rows a stage depends on
  function automatic logic stage_needs(input logic [STAGE_W-1:0] stg, input logic [1:0] ofs);
    logic need;
    need = 1'b1;
    case (stg)
      STG_DBK_V: need = (ofs != OFS_ABOVE);
      STG_DBK_H: need = (ofs != OFS_BELOW);
      STG_SAO_A: need = (ofs != OFS_ABOVE);
      default:   need = 1'b1;
    endcase
    return need;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/wfs_ifs.sv */
// valid/ready channel interfaces for request and result words
`default_nettype none

interface wfs_in_if import wfs_pkg::*;;
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [ROW_W-1:0]   row_index;
  logic [COUNT_W-1:0] unit_count;
  logic [STAGE_W-1:0] stage_index;
  logic [FAULT_W-1:0] fault_code;

  modport source (output valid, action, row_index, unit_count, stage_index, fault_code,
                  input ready);
  modport sink (input valid, action, row_index, unit_count, stage_index, fault_code,
                output ready);
endinterface

interface wfs_out_if import wfs_pkg::*;;
  logic               valid;
  logic               ready;
  logic               granted;
  logic               task_found;
  logic [STAGE_W-1:0] task_stage;
  logic [ROW_W-1:0]   task_row;
  logic               all_done;
  logic [FAULT_W-1:0] first_fault;

  modport source (output valid, granted, task_found, task_stage, task_row, all_done,
                  first_fault, input ready);
  modport sink (input valid, granted, task_found, task_stage, task_row, all_done,
                first_fault, output ready);
endinterface

`default_nettype wire

/* hw/rtl/wfs_ctrl.sv */
// row store memories and the sequencer that reads, updates and writes them
`default_nettype none

module wfs_ctrl import wfs_pkg::*; #(
  parameter int MAX_ROWS = WFS_MAX_ROWS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire wfs_cfg_t cfg,
  wfs_in_if.sink        in_if,
  wfs_out_if.source     out_if
);

  localparam int AW = $clog2(MAX_ROWS);
  localparam int TW = $clog2(4 * MAX_ROWS + 1);

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_STAGE = 6'b000100,
    ST_READ  = 6'b001000,
    ST_EVAL  = 6'b010000,
    ST_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic               granted;
    logic               task_found;
    logic [STAGE_W-1:0] task_stage;
    logic [ROW_W-1:0]   task_row;
  } res_t;

  logic [COUNT_W-1:0] prog_mem [MAX_ROWS];
  logic [3:0]         done_mem [MAX_ROWS];

  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic [3:0]         clr_bits_r, clr_bits_nxt;
  logic               reply_r, reply_nxt;
  action_t            act_r, act_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [STAGE_W-1:0] fstg_r, fstg_nxt;
  logic [STAGE_W-1:0] stg_r, stg_nxt;
  logic [1:0]         off_r, off_nxt;
  logic               ok_r, ok_nxt;
  logic [CFG_W-1:0]   next_row_r [4];
  logic [CFG_W-1:0]   next_row_nxt [4];
  logic [TW-1:0]      tasks_r, tasks_nxt;
  logic [FAULT_W-1:0] fault_r, fault_nxt;
  res_t               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_res_r, out_res_nxt;
  logic               out_done_r, out_done_nxt;
  logic [FAULT_W-1:0] out_fault_r, out_fault_nxt;

  logic [COUNT_W-1:0] prog_rd_r;
  logic [3:0]         done_rd_r;

  logic               prog_we, done_we;
  logic [AW-1:0]      prog_wa, done_wa, rd_addr;
  logic [COUNT_W-1:0] prog_wd;
  logic [3:0]         done_wd;

  logic [AW+ROW_W-1:0] in_row_w, row_w;
  logic [AW+CFG_W-1:0] tgt_w;
  logic [AW-1:0]       in_addr, row_addr;
  logic                in_row_ok;
  logic [CFG_W-1:0]    cur_c, tgt;
  logic                above_ok, below_ok, need, cond_claim, ok_v;
  logic                fin_stage, fin_ok, out_free;
  logic [TW-1:0]       rows_t;
  logic [3:0]          off_bits;

  always_ff @(posedge clk) begin
    if (prog_we) begin
      prog_mem[prog_wa] <= prog_wd;
    end
    if (done_we) begin
      done_mem[done_wa] <= done_wd;
    end
    prog_rd_r <= prog_mem[rd_addr];
    done_rd_r <= done_mem[rd_addr];
  end

  assign in_row_w  = {{AW{1'b0}}, in_if.row_index};
  assign in_addr   = in_row_w[AW-1:0];
  assign row_w     = {{AW{1'b0}}, row_r};
  assign row_addr  = row_w[AW-1:0];
  assign in_row_ok = {1'b0, in_if.row_index} < cfg.rows;

  assign cur_c    = next_row_r[stg_r];
  assign above_ok = cur_c != '0;
  assign below_ok = (cur_c + 9'd1) < cfg.rows;

  always_comb begin
    case (off_r)
      OFS_ABOVE: tgt = cur_c - 9'd1;
      OFS_SELF:  tgt = cur_c;
      default:   tgt = cur_c + 9'd1;
    endcase
  end

  assign tgt_w = {{AW{1'b0}}, tgt};
  assign need  = stage_needs(stg_r, off_r) &&
                 ((off_r == OFS_ABOVE) ? above_ok : ((off_r == OFS_BELOW) ? below_ok : 1'b1));
  assign cond_claim = (stg_r == STG_DBK_V) ? (prog_rd_r >= cfg.cols)
                                           : done_rd_r[stg_r - 2'd1];
  assign ok_v     = ok_r & cond_claim;
  assign out_free = !out_valid_r || out_if.ready;
  assign rows_t   = TW'(cfg.rows);
  assign off_bits = {!cfg.sao, !cfg.sao, !cfg.deblock, !cfg.deblock};

  always_comb begin
    state_nxt     = state_r;
    clr_addr_nxt  = clr_addr_r;
    clr_bits_nxt  = clr_bits_r;
    reply_nxt     = reply_r;
    act_nxt       = act_r;
    row_nxt       = row_r;
    cnt_nxt       = cnt_r;
    fstg_nxt      = fstg_r;
    stg_nxt       = stg_r;
    off_nxt       = off_r;
    ok_nxt        = ok_r;
    next_row_nxt  = next_row_r;
    tasks_nxt     = tasks_r;
    fault_nxt     = fault_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    out_done_nxt  = out_done_r;
    out_fault_nxt = out_fault_r;
    out_valid_nxt = out_valid_r && !out_if.ready;
    prog_we       = 1'b0;
    prog_wa       = in_addr;
    prog_wd       = in_if.unit_count;
    done_we       = 1'b0;
    done_wa       = row_addr;
    done_wd       = done_rd_r | (4'b0001 << fstg_r);
    rd_addr       = in_addr;
    in_if.ready   = 1'b0;
    fin_stage     = 1'b0;
    fin_ok        = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        prog_we      = 1'b1;
        prog_wa      = clr_addr_r;
        prog_wd      = '0;
        done_we      = 1'b1;
        done_wa      = clr_addr_r;
        done_wd      = clr_bits_r;
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == AW'(MAX_ROWS - 1)) begin
          state_nxt = reply_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_if.ready = 1'b1;
        if (in_if.valid) begin
          act_nxt   = action_t'(in_if.action);
          row_nxt   = in_if.row_index;
          cnt_nxt   = in_if.unit_count;
          fstg_nxt  = in_if.stage_index;
          res_nxt   = '0;
          state_nxt = ST_DONE;
          unique case (in_if.action)
            ACT_START: begin
              fault_nxt    = '0;
              tasks_nxt    = (cfg.deblock ? (rows_t << 1) : '0) +
                             (cfg.sao ? (rows_t << 1) : '0);
              for (int s = 0; s < 4; s++) begin
                next_row_nxt[s] = off_bits[s] ? cfg.rows : '0;
              end
              clr_bits_nxt = off_bits;
              clr_addr_nxt = '0;
              reply_nxt    = 1'b1;
              state_nxt    = ST_CLEAR;
            end
            ACT_PUBLISH: begin
              prog_we = in_row_ok;
            end
            ACT_QUERY: begin
              if (in_row_ok && fault_r == '0) begin
                state_nxt = ST_EVAL;
              end
            end
            ACT_CLAIM: begin
              if (tasks_r != '0 && fault_r == '0) begin
                stg_nxt   = STG_SAO_B;
                state_nxt = ST_STAGE;
              end
            end
            ACT_FINISH: begin
              if (in_row_ok) begin
                state_nxt = ST_EVAL;
              end
            end
            ACT_FAULT: begin
              if (fault_r == '0 && in_if.fault_code != '0) begin
                fault_nxt = in_if.fault_code;
              end
            end
            default: ;
          endcase
        end
      end
      ST_STAGE: begin
        if (cur_c < cfg.rows) begin
          off_nxt   = OFS_ABOVE;
          ok_nxt    = 1'b1;
          state_nxt = ST_READ;
        end else if (stg_r == STG_DBK_V) begin
          state_nxt = ST_DONE;
        end else begin
          stg_nxt = stg_r - 2'd1;
        end
      end
      ST_READ: begin
        rd_addr = tgt_w[AW-1:0];
        if (need) begin
          state_nxt = ST_EVAL;
        end else if (off_r == OFS_BELOW) begin
          fin_stage = 1'b1;
          fin_ok    = ok_r;
        end else begin
          off_nxt = off_r + 2'd1;
        end
      end
      ST_EVAL: begin
        case (act_r)
          ACT_QUERY: begin
            res_nxt.granted = prog_rd_r >= cnt_r;
            state_nxt       = ST_DONE;
          end
          ACT_FINISH: begin
            if (!done_rd_r[fstg_r]) begin
              done_we = 1'b1;
              if (tasks_r != '0) begin
                tasks_nxt = tasks_r - 1'b1;
              end
            end
            state_nxt = ST_DONE;
          end
          default: begin
            ok_nxt = ok_v;
            if (off_r == OFS_BELOW) begin
              fin_stage = 1'b1;
              fin_ok    = ok_v;
            end else begin
              off_nxt   = off_r + 2'd1;
              state_nxt = ST_READ;
            end
          end
        endcase
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_res_nxt   = res_r;
          out_done_nxt  = tasks_r == '0;
          out_fault_nxt = fault_r;
          reply_nxt     = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // end of a stage check: grant it, move on to the next lower stage, or end with no task after the lowest
    if (fin_stage) begin
      if (fin_ok) begin
        next_row_nxt[stg_r] = cur_c + 9'd1;
        res_nxt.task_found  = 1'b1;
        res_nxt.task_stage  = stg_r;
        res_nxt.task_row    = cur_c[ROW_W-1:0];
        state_nxt           = ST_DONE;
      end else if (stg_r == STG_DBK_V) begin
        state_nxt = ST_DONE;
      end else begin
        stg_nxt   = stg_r - 2'd1;
        state_nxt = ST_STAGE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      clr_bits_r  <= '0;
      reply_r     <= 1'b0;
      tasks_r     <= '0;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
      for (int s = 0; s < 4; s++) begin
        next_row_r[s] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= clr_addr_nxt;
      clr_bits_r  <= clr_bits_nxt;
      reply_r     <= reply_nxt;
      tasks_r     <= tasks_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
      next_row_r  <= next_row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    row_r       <= row_nxt;
    cnt_r       <= cnt_nxt;
    fstg_r      <= fstg_nxt;
    stg_r       <= stg_nxt;
    off_r       <= off_nxt;
    ok_r        <= ok_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
    out_done_r  <= out_done_nxt;
    out_fault_r <= out_fault_nxt;
  end

  assign out_if.valid       = out_valid_r;
  assign out_if.granted     = out_res_r.granted;
  assign out_if.task_found  = out_res_r.task_found;
  assign out_if.task_stage  = out_res_r.task_stage;
  assign out_if.task_row    = out_res_r.task_row;
  assign out_if.all_done    = out_done_r;
  assign out_if.first_fault = out_fault_r;

endmodule

`default_nettype wire

/* hw/rtl/wavefront_filter_scoreboard.sv */
// top level: configuration registers, geometry clamping and the scoreboard sequencer
//
// in_if carries request words (action, row_index, unit_count, stage_index,
// fault_code); out_if returns one result word per request. Both are
// valid/ready; a word moves when valid and ready are high at a clock edge.
// cfg_we/cfg_index/cfg_data write the four registers; write only while idle.
// One request is worked at a time; in_if.ready is high only when the
// sequencer is idle. Results sit in an output register, so the next request
// is taken while an earlier result waits. Query and finish make one memory
// read unless refused; claim tries the four stages in turn, from the highest
// down, reading neighbor rows from the row store and skipping the neighbor
// slots a stage does not need; start picture runs a pass that rewrites
// every row store entry one per cycle.
// After reset the same clearing pass runs with ready low.
// When out_if.ready is low the finished result waits in the sequencer and no
// further request is taken until the output register frees.
`default_nettype none

module wavefront_filter_scoreboard import wfs_pkg::*; #(
  parameter int MAX_ROWS    = WFS_MAX_ROWS,
  parameter int MAX_COLUMNS = WFS_MAX_COLUMNS
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  wfs_in_if.sink                 in_if,
  wfs_out_if.source              out_if,
  input  wire logic              cfg_we,
  input  wire logic [CIDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic             deblock_r, deblock_nxt;
  logic             sao_r, sao_nxt;
  wfs_cfg_t         cfg_c;

  always_comb begin
    rows_nxt    = rows_r;
    cols_nxt    = cols_r;
    deblock_nxt = deblock_r;
    sao_nxt     = sao_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS:    rows_nxt    = cfg_data;
        CFG_COLUMNS: cols_nxt    = cfg_data;
        CFG_DEBLOCK: deblock_nxt = cfg_data[0];
        CFG_SAO:     sao_nxt     = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= 9'd1;
      cols_r    <= 9'd1;
      deblock_r <= 1'b1;
      sao_r     <= 1'b1;
    end else begin
      rows_r    <= rows_nxt;
      cols_r    <= cols_nxt;
      deblock_r <= deblock_nxt;
      sao_r     <= sao_nxt;
    end
  end

  // zero counts as one, above the maximum counts as the maximum
  always_comb begin
    if (rows_r == '0) begin
      cfg_c.rows = 9'd1;
    end else if (32'(rows_r) > MAX_ROWS) begin
      cfg_c.rows = CFG_W'(MAX_ROWS);
    end else begin
      cfg_c.rows = rows_r;
    end
    if (cols_r == '0) begin
      cfg_c.cols = 9'd1;
    end else if (32'(cols_r) > MAX_COLUMNS) begin
      cfg_c.cols = CFG_W'(MAX_COLUMNS);
    end else begin
      cfg_c.cols = cols_r;
    end
    cfg_c.deblock = deblock_r;
    cfg_c.sao     = sao_r;
  end

  wfs_ctrl #(
    .MAX_ROWS (MAX_ROWS)
  ) u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_c),
    .in_if  (in_if),
    .out_if (out_if)
  );

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("request taken while another is in progress");

  a_fault_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.first_fault != '0 |-> !out_if.granted && !out_if.task_found)
    else $error("grant or task given out with a fault latched");

  a_task_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.task_found |-> !out_if.all_done)
    else $error("task given out with no tasks remaining");

endmodule

`default_nettype wire
